// File: design/ascii_pan_tilt_slew_controller_assert.svh
// Assertion macros used by the checker file of the pan/tilt slew controller.
// No dependencies; include by bare file name.
`ifndef ASCII_PAN_TILT_SLEW_CONTROLLER_ASSERT_SVH
`define ASCII_PAN_TILT_SLEW_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define APTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apts assertion failed: implication");

// Next-cycle implication, disabled while in reset.
`define APTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apts assertion failed: next-cycle implication");

`endif

// File: design/apts_pkg.sv
// Shared types and constants of the pan/tilt slew controller.
// No dependencies; imported by the interfaces, the top level and the checker.
package apts_pkg;

  localparam int ANGLE_BITS  = 8;
  localparam int ACC_W       = ANGLE_BITS + 1;
  localparam int PROD_W      = ACC_W + 4;
  localparam int LIMIT_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int OUT_ANGLE_W = 8;

  localparam logic [ACC_W-1:0]      ACC_MAX     = {ACC_W{1'b1}};
  localparam logic [ANGLE_BITS-1:0] HOME_ANGLE  = ANGLE_BITS'(90);
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(180);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [ACC_W-1:0] accum;
    logic [1:0]       phase;
    logic             negative;
  } num_field_t;

  typedef struct packed {
    logic [OUT_ANGLE_W-1:0] pan_angle;
    logic [OUT_ANGLE_W-1:0] tilt_angle;
    logic                   moving;
    logic                   busy_led;
  } out_item_t;

endpackage

// File: design/apts_if.sv
// Valid/ready channel interfaces of the pan/tilt slew controller.
// Depends on apts_pkg for payload widths.
interface apts_in_if;
  import apts_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, kind, rx_byte, input ready);
  modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface apts_out_if;
  import apts_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OUT_ANGLE_W-1:0] pan_angle;
  logic [OUT_ANGLE_W-1:0] tilt_angle;
  logic                   moving;
  logic                   busy_led;
  modport source (output valid, pan_angle, tilt_angle, moving, busy_led, input ready);
  modport sink (input valid, pan_angle, tilt_angle, moving, busy_led, output ready);
endinterface

// File: design/ascii_pan_tilt_slew_controller.sv
// Pan/tilt slew controller with an ASCII "X,Y" line parser.
// Depends on apts_pkg and the channel interfaces in apts_if.sv.
// Usage:
//   in_ch carries one item per handshake: a serial byte (kind 0) or a step
//   tick (kind 1). Bytes build a line "X,Y" ended by a newline; a valid line
//   loads the axis targets and sets the busy LED. Bytes give no result.
//   Each tick steps both axes one degree toward their targets and gives one
//   result on out_ch: both angles, the moving flag and the LED state.
//   cfg_we/cfg_wdata write angle_limit (largest accepted target); write it
//   only while no tick result is pending.
// Timing:
//   One item per cycle while in_ch.ready is high. The parser and the axis
//   steppers update their state registers in the cycle an item is accepted;
//   a tick's result is shown on out_ch from the output register.
//   If out_ch stalls, one further tick result goes to a skid register and
//   in_ch.ready drops only while both registers hold results.
// Reset:
//   Synchronous rst_n low returns the angles and targets to 90 degrees,
//   angle_limit to 180, clears the LED and the line parser, and empties
//   both output registers. No clearing pass is needed.
module ascii_pan_tilt_slew_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [apts_pkg::LIMIT_W-1:0] cfg_wdata,
  apts_in_if.sink                      in_ch,
  apts_out_if.source                   out_ch
);
  import apts_pkg::*;

  logic [LIMIT_W-1:0]    limit_r;
  logic [ANGLE_BITS-1:0] pan_now_r, pan_now_nxt, pan_goal_r, pan_goal_nxt;
  logic [ANGLE_BITS-1:0] tilt_now_r, tilt_now_nxt, tilt_goal_r, tilt_goal_nxt;
  logic                  led_r, led_nxt;
  logic                  second_r, second_nxt;
  logic                  text_seen_r, text_seen_nxt;
  logic                  comma_ok_r, comma_ok_nxt;
  num_field_t            pan_num_r, pan_num_nxt, tilt_num_r, tilt_num_nxt;

  logic                  out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  out_item_t             out_item_r, out_item_nxt, skid_item_r, skid_item_nxt;

  logic                  in_acc, push, pop, moved_pan, moved_tilt;
  out_item_t             tick_item;
  logic [BYTE_W-1:0]     c;

  function automatic logic is_space(logic [BYTE_W-1:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) ||
           (ch == CH_FF) || (ch == CH_CR);
  endfunction

  // atol-style digit accumulation with a saturating magnitude
  function automatic num_field_t field_feed(num_field_t f, logic [BYTE_W-1:0] ch);
    num_field_t        r;
    logic              digit;
    logic              take;
    logic [PROD_W-1:0] v;
    r     = f;
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    take  = 1'b0;
    v     = '0;
    case (f.phase)
      PH_WAIT: begin
        if (!is_space(ch)) begin
          if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
            r.negative = (ch == CH_MINUS);
            r.phase    = PH_DIGITS;
          end else if (!digit) begin
            r.phase = PH_DONE;
          end else begin
            r.phase = PH_DIGITS;
            take    = 1'b1;
          end
        end
      end
      PH_DIGITS: begin
        if (!digit) begin
          r.phase = PH_DONE;
        end else begin
          take = 1'b1;
        end
      end
      default: r = f;
    endcase
    if (take) begin
      v = PROD_W'(f.accum) * PROD_W'(10) + PROD_W'(ch - CH_ZERO);
      r.accum = (v > PROD_W'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] field_apply(num_field_t f,
                                                        logic [ANGLE_BITS-1:0] goal,
                                                        logic [LIMIT_W-1:0] lim);
    logic [ANGLE_BITS-1:0] g;
    g = goal;
    if (!(f.negative && (f.accum != '0)) && (f.accum <= ACC_W'(lim))) begin
      g = f.accum[ANGLE_BITS-1:0];
    end
    return g;
  endfunction

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && !skid_valid_r;
  assign c           = in_ch.rx_byte;
  assign pop         = out_valid_r && out_ch.ready;

  always_comb begin
    pan_now_nxt   = pan_now_r;
    pan_goal_nxt  = pan_goal_r;
    tilt_now_nxt  = tilt_now_r;
    tilt_goal_nxt = tilt_goal_r;
    led_nxt       = led_r;
    second_nxt    = second_r;
    text_seen_nxt = text_seen_r;
    comma_ok_nxt  = comma_ok_r;
    pan_num_nxt   = pan_num_r;
    tilt_num_nxt  = tilt_num_r;
    moved_pan     = 1'b0;
    moved_tilt    = 1'b0;
    push          = 1'b0;

    if (in_acc && (in_ch.kind == KIND_BYTE)) begin
      if (c == CH_NL) begin
        if (second_r && comma_ok_r) begin
          pan_goal_nxt  = field_apply(pan_num_r, pan_goal_r, limit_r);
          tilt_goal_nxt = field_apply(tilt_num_r, tilt_goal_r, limit_r);
          led_nxt       = 1'b1;
        end
        second_nxt    = 1'b0;
        text_seen_nxt = 1'b0;
        comma_ok_nxt  = 1'b0;
        pan_num_nxt   = '0;
        tilt_num_nxt  = '0;
      end else if (!second_r) begin
        if (c == CH_COMMA) begin
          second_nxt   = 1'b1;
          comma_ok_nxt = text_seen_r;
        end else begin
          if (!is_space(c)) begin
            text_seen_nxt = 1'b1;
          end
          pan_num_nxt = field_feed(pan_num_r, c);
        end
      end else begin
        tilt_num_nxt = field_feed(tilt_num_r, c);
      end
    end else if (in_acc) begin
      push = 1'b1;
      if (pan_now_r != pan_goal_r) begin
        moved_pan   = 1'b1;
        pan_now_nxt = (pan_now_r < pan_goal_r) ? pan_now_r + 1'b1 : pan_now_r - 1'b1;
      end
      if (tilt_now_r != tilt_goal_r) begin
        moved_tilt   = 1'b1;
        tilt_now_nxt = (tilt_now_r < tilt_goal_r) ? tilt_now_r + 1'b1 : tilt_now_r - 1'b1;
      end
      if (!(moved_pan || moved_tilt)) begin
        led_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    tick_item.pan_angle  = OUT_ANGLE_W'(pan_now_nxt);
    tick_item.tilt_angle = OUT_ANGLE_W'(tilt_now_nxt);
    tick_item.moving     = moved_pan || moved_tilt;
    tick_item.busy_led   = led_nxt;
  end

  // output register plus one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_item_nxt   = skid_item_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_item_nxt  = tick_item;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_item_nxt  = tick_item;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= LIMIT_RESET;
      pan_now_r    <= HOME_ANGLE;
      pan_goal_r   <= HOME_ANGLE;
      tilt_now_r   <= HOME_ANGLE;
      tilt_goal_r  <= HOME_ANGLE;
      led_r        <= 1'b0;
      second_r     <= 1'b0;
      text_seen_r  <= 1'b0;
      comma_ok_r   <= 1'b0;
      pan_num_r    <= '0;
      tilt_num_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      pan_now_r    <= pan_now_nxt;
      pan_goal_r   <= pan_goal_nxt;
      tilt_now_r   <= tilt_now_nxt;
      tilt_goal_r  <= tilt_goal_nxt;
      led_r        <= led_nxt;
      second_r     <= second_nxt;
      text_seen_r  <= text_seen_nxt;
      comma_ok_r   <= comma_ok_nxt;
      pan_num_r    <= pan_num_nxt;
      tilt_num_r   <= tilt_num_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pan_angle  = out_item_r.pan_angle;
  assign out_ch.tilt_angle = out_item_r.tilt_angle;
  assign out_ch.moving     = out_item_r.moving;
  assign out_ch.busy_led   = out_item_r.busy_led;

endmodule

// File: design/apts_checker.sv
// Port-level checker for the pan/tilt slew controller, bound to the top level.
// Depends on apts_pkg and ascii_pan_tilt_slew_controller_assert.svh.
`include "ascii_pan_tilt_slew_controller_assert.svh"

module apts_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [apts_pkg::OUT_ANGLE_W-1:0] out_pan_angle,
  input logic [apts_pkg::OUT_ANGLE_W-1:0] out_tilt_angle,
  input logic                             out_moving,
  input logic                             out_busy_led
);
  import apts_pkg::*;

  logic                       stalled;
  logic [2*OUT_ANGLE_W+1:0]   out_payload;
  assign stalled     = out_valid && !out_ready;
  assign out_payload = {out_pan_angle, out_tilt_angle, out_moving, out_busy_led};

  `APTS_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_valid)
  `APTS_ASSERT_NXT(a_out_stable, clk, rst_n, stalled, $stable(out_payload))
  // input backs up only when a result is already waiting
  `APTS_ASSERT_IMP(a_ready_low_has_result, clk, rst_n, !in_ready, out_valid)
  // coming out of reset, no result may be shown yet
  `APTS_ASSERT_IMP(a_reset_empty, clk, rst_n, $past(!rst_n), !out_valid && in_ready)
  // a result appears only after an accepted item
  `APTS_ASSERT_IMP(a_result_from_item, clk, rst_n, out_valid && !$past(out_valid), $past(in_valid && in_ready))

endmodule

bind ascii_pan_tilt_slew_controller apts_port_checker u_apts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pan_angle  (out_ch.pan_angle),
  .out_tilt_angle (out_ch.tilt_angle),
  .out_moving     (out_ch.moving),
  .out_busy_led   (out_ch.busy_led)
);
